[rtl/cbrx_pkg.sv]
// types, constants and codes shared by the checksummed block receiver
`timescale 1ns / 1ps
package cbrx_pkg;

  localparam int unsigned BLOCK_BYTES = 1024;
  localparam int unsigned IMAGE_BYTES = 2097152;
  localparam int unsigned NUM_BLOCKS  = (IMAGE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;

  localparam int unsigned POS_W  = $clog2(BLOCK_BYTES + 2);
  localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned ADDR_W = 21;
  localparam int unsigned SUM_W  = 16;

  localparam logic [7:0] ACK_BYTE    = 8'hDA;
  localparam logic [7:0] NAK_BYTE    = 8'h00;
  localparam logic [7:0] CANCEL_BYTE = 8'hCC;
  localparam logic [7:0] MODEL_MARK  = 8'h20;
  localparam int unsigned MODEL_ADDR = 5;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_ERROR  = 2'd1,
    OP_CANCEL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    PH_RECEIVING = 2'd0,
    PH_COMPLETE  = 2'd1,
    PH_CANCELLED = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] store_address;
    logic [7:0]        store_byte;
    logic [7:0]        reply_byte;
    logic              model_flag;
    logic              complete;
    logic              cancelled;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [SUM_W-1:0]  sum;
    logic [7:0]        chk_hi;
    logic [BLK_W-1:0]  blk;
    logic [ADDR_W-1:0] base;
    logic              none_yet;
    logic              model;
    phase_e            phase;
  } rx_state_t;

endpackage

[rtl/cbrx_if.sv]
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
interface cbrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface cbrx_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [20:0] store_address;
  logic [7:0]  store_byte;
  logic [7:0]  reply_byte;
  logic        model_flag;
  logic        complete;
  logic        cancelled;

  modport source (output valid, output kind, output store_address, output store_byte,
                  output reply_byte, output model_flag, output complete,
                  output cancelled, input ready);
  modport sink (input valid, input kind, input store_address, input store_byte,
                input reply_byte, input model_flag, input complete, input cancelled,
                output ready);
endinterface

[rtl/checksummed_block_receiver_unit.sv]
// checksummed block receiver: top level with input and result registers
//
// in_i carries one word per handshake: an opcode (received byte, receive error,
// cancel) and the received byte. out_o delivers at most one word per input word:
// either a data byte to store with its image address, or a reply byte for the
// link (ack, nak or cancel) with the model, complete and cancelled flags.
// A word is taken into an input register, processed by a single level of logic
// against the receiver state, and its result is loaded into an output register.
// One word is accepted every cycle unless out_o stalls; the input register moves
// on whenever the output register is empty, is being read, or the word produces
// no result. If the receiver stalls out_o, the input register holds one more word
// and then in_i.ready drops until the output register is read.
// Reset clears the state to the start of block 0 with nothing received yet.
// After completion or cancel every word is consumed with no result until reset.
`timescale 1ns / 1ps
module checksummed_block_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbrx_in_if.sink    in_i,
  cbrx_out_if.source out_o
);
  import cbrx_pkg::*;

  logic      in_valid_q;
  in_word_t  in_q;
  rx_state_t state_q, state_d;
  logic      out_valid_q;
  out_word_t out_q;
  logic      has_res;
  out_word_t res;
  logic      advance;

  cbrx_step u_step (
    .state_i   (state_q),
    .word_i    (in_q),
    .state_o   (state_d),
    .has_res_o (has_res),
    .res_o     (res)
  );

  assign advance     = in_valid_q && (!has_res || !out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      state_q.pos      <= '0;
      state_q.sum      <= '0;
      state_q.chk_hi   <= '0;
      state_q.blk      <= '0;
      state_q.base     <= '0;
      state_q.none_yet <= 1'b1;
      state_q.model    <= 1'b0;
      state_q.phase    <= PH_RECEIVING;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.opcode  <= in_i.opcode;
      in_q.rx_byte <= in_i.rx_byte;
    end
    if (advance && has_res) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.store_address = out_q.store_address;
  assign out_o.store_byte    = out_q.store_byte;
  assign out_o.reply_byte    = out_q.reply_byte;
  assign out_o.model_flag    = out_q.model_flag;
  assign out_o.complete      = out_q.complete;
  assign out_o.cancelled     = out_q.cancelled;

  // byte position never runs past the checksum low byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= POS_W'(BLOCK_BYTES + 1))
    else $error("byte position out of range");

  // once stopped, no new result is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_RECEIVING) && !out_valid_q |=> !out_valid_q)
    else $error("result after transfer stopped");

  // completion only on an ack reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.complete |-> out_q.kind == KIND_REPLY && out_q.reply_byte == ACK_BYTE)
    else $error("complete flag on a non-ack word");

  // a store word carries no reply byte and no complete or cancelled flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_STORE |->
      out_q.reply_byte == NAK_BYTE && !out_q.complete && !out_q.cancelled)
    else $error("store word with reply fields set");

  // a pending result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !(advance && has_res))
    else $error("result register overwritten");

endmodule

[rtl/cbrx_step.sv]
// next-state and result logic for one received word
`timescale 1ns / 1ps
module cbrx_step (
  input  cbrx_pkg::rx_state_t state_i,
  input  cbrx_pkg::in_word_t  word_i,
  output cbrx_pkg::rx_state_t state_o,
  output logic                has_res_o,
  output cbrx_pkg::out_word_t res_o
);
  import cbrx_pkg::*;

  always_comb begin
    state_o   = state_i;
    has_res_o = 1'b0;
    res_o     = '0;
    if (state_i.phase == PH_RECEIVING) begin
      case (word_i.opcode)
        OP_CANCEL: begin
          state_o.phase   = PH_CANCELLED;
          has_res_o       = 1'b1;
          res_o.kind      = KIND_REPLY;
          res_o.reply_byte = CANCEL_BYTE;
          res_o.cancelled = 1'b1;
        end
        OP_ERROR: begin
          if (!state_i.none_yet) begin
            state_o.pos      = '0;
            state_o.sum      = '0;
            state_o.chk_hi   = '0;
            has_res_o        = 1'b1;
            res_o.kind       = KIND_REPLY;
            res_o.reply_byte = NAK_BYTE;
          end
        end
        OP_BYTE: begin
          if (state_i.pos < POS_W'(BLOCK_BYTES)) begin
            // data byte
            if (state_i.blk == '0 && state_i.pos == POS_W'(MODEL_ADDR)) begin
              state_o.model = (word_i.rx_byte == MODEL_MARK);
            end
            state_o.sum         = state_i.sum + SUM_W'(word_i.rx_byte);
            state_o.pos         = state_i.pos + POS_W'(1);
            state_o.none_yet    = 1'b0;
            has_res_o           = 1'b1;
            res_o.kind          = KIND_STORE;
            res_o.store_address = state_i.base + ADDR_W'(state_i.pos);
            res_o.store_byte    = word_i.rx_byte;
          end else if (state_i.pos == POS_W'(BLOCK_BYTES)) begin
            state_o.chk_hi = word_i.rx_byte;
            state_o.pos    = state_i.pos + POS_W'(1);
          end else begin
            // checksum low byte closes the block
            state_o.pos    = '0;
            state_o.sum    = '0;
            state_o.chk_hi = '0;
            has_res_o      = 1'b1;
            res_o.kind     = KIND_REPLY;
            if ({state_i.chk_hi, word_i.rx_byte} == state_i.sum) begin
              state_o.blk      = state_i.blk + BLK_W'(1);
              state_o.base     = state_i.base + ADDR_W'(BLOCK_BYTES);
              res_o.reply_byte = ACK_BYTE;
              if (state_i.blk == BLK_W'(NUM_BLOCKS - 1)) begin
                state_o.phase  = PH_COMPLETE;
                res_o.complete = 1'b1;
              end
            end else begin
              res_o.reply_byte = NAK_BYTE;
            end
          end
        end
        default: begin
          has_res_o = 1'b0;
        end
      endcase
    end
    res_o.model_flag = state_o.model;
  end

endmodule

[test/tb.sv]
// testbench for the checksummed block receiver: predicts every store and reply word and checks it
`timescale 1ns / 1ps
module tb;
  import cbrx_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    SEND_GOOD,
    SEND_BAD_SUM,
    SEND_ERR_DATA,
    SEND_ERR_SUM
  } block_end_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbrx_in_if  in_if ();
  cbrx_out_if out_if ();

  checksummed_block_receiver_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // receiver state as seen by the predictor
  logic [POS_W-1:0] rx_pos;
  logic [SUM_W-1:0] rx_sum;
  logic [7:0]       rx_chk_hi;
  int unsigned      rx_blk;
  logic             rx_none_yet;
  logic             rx_model;
  phase_e           rx_phase;

  out_word_t due_words[$];
  int        mismatch_count = 0;
  int        word_count = 0;
  int        long_hold_cycles = 0;
  bit        idle_on = 1'b1;

  task automatic advance_receiver(input logic [1:0] op, input logic [7:0] b);
    out_word_t       w;
    logic            has;
    longint unsigned addr;
    w = '0;
    has = 1'b0;
    if (rx_phase == PH_RECEIVING) begin
      case (op)
        OP_CANCEL: begin
          rx_phase = PH_CANCELLED;
          w.kind = KIND_REPLY;
          w.reply_byte = CANCEL_BYTE;
          w.cancelled = 1'b1;
          has = 1'b1;
        end
        OP_ERROR: begin
          if (!rx_none_yet) begin
            rx_pos = '0;
            rx_sum = '0;
            rx_chk_hi = '0;
            w.kind = KIND_REPLY;
            w.reply_byte = NAK_BYTE;
            has = 1'b1;
          end
        end
        OP_BYTE: begin
          if (rx_pos < BLOCK_BYTES) begin
            addr = longint'(rx_blk) * BLOCK_BYTES + rx_pos;
            if (addr == MODEL_ADDR) rx_model = (b == MODEL_MARK);
            rx_sum = rx_sum + SUM_W'(b);
            rx_pos = rx_pos + 1'b1;
            rx_none_yet = 1'b0;
            w.kind = KIND_STORE;
            w.store_address = ADDR_W'(addr);
            w.store_byte = b;
            has = 1'b1;
          end else if (rx_pos == BLOCK_BYTES) begin
            rx_chk_hi = b;
            rx_pos = rx_pos + 1'b1;
          end else begin
            w.kind = KIND_REPLY;
            has = 1'b1;
            if ({rx_chk_hi, b} != rx_sum) begin
              w.reply_byte = NAK_BYTE;
            end else begin
              rx_blk++;
              w.reply_byte = ACK_BYTE;
              if (longint'(rx_blk) * BLOCK_BYTES >= IMAGE_BYTES) begin
                rx_phase = PH_COMPLETE;
                w.complete = 1'b1;
              end
            end
            rx_pos = '0;
            rx_sum = '0;
            rx_chk_hi = '0;
          end
        end
        default: ;
      endcase
    end
    if (has) begin
      w.model_flag = rx_model;
      due_words.push_back(w);
    end
  endtask

  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_receiver(op, b);
    if (op != OP_UNUSED) word_count++;
  endtask

  task automatic wait_drained;
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
  endtask

  task automatic send_block(input block_end_e how, input fill_e fill, input bit mark);
    logic [15:0] total;
    logic [15:0] sent_sum;
    logic [7:0]  b;
    int          stop_at;
    total = '0;
    stop_at = (how == SEND_ERR_DATA) ? $urandom_range(0, BLOCK_BYTES - 1) : BLOCK_BYTES;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 63) == 0) send_word(OP_UNUSED, 8'($urandom));
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (mark && i == MODEL_ADDR) b = MODEL_MARK;
      total = total + 16'(b);
      send_word(OP_BYTE, b);
    end
    case (how)
      SEND_GOOD, SEND_BAD_SUM: begin
        sent_sum = total;
        if (how == SEND_BAD_SUM) sent_sum = total ^ 16'($urandom_range(1, 65535));
        send_word(OP_BYTE, sent_sum[15:8]);
        send_word(OP_BYTE, sent_sum[7:0]);
      end
      SEND_ERR_SUM: begin
        if ($urandom_range(0, 1) == 1) send_word(OP_BYTE, total[15:8]);
        send_word(OP_ERROR, 8'($urandom));
      end
      default: send_word(OP_ERROR, 8'($urandom));
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s expected %0h actual %0h", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_words.size() == 0) begin
        $error("result word with none expected");
        mismatch_count++;
      end else begin
        w = due_words.pop_front();
        check_field("kind", 32'(w.kind), 32'(out_if.kind));
        check_field("store_address", 32'(w.store_address), 32'(out_if.store_address));
        check_field("store_byte", 32'(w.store_byte), 32'(out_if.store_byte));
        check_field("reply_byte", 32'(w.reply_byte), 32'(out_if.reply_byte));
        check_field("model_flag", 32'(w.model_flag), 32'(out_if.model_flag));
        check_field("complete", 32'(w.complete), 32'(out_if.complete));
        check_field("cancelled", 32'(w.cancelled), 32'(out_if.cancelled));
      end
    end
  end

  // result side: random stalls and an occasional long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk_i);
        long_hold_cycles = 0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_link_events;
    send_word(OP_ERROR, 8'hFF);
    send_word(OP_UNUSED, 8'h00);
    send_word(OP_ERROR, 8'h00);
    send_word(OP_UNUSED, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'h7F);
    send_word(OP_BYTE, MODEL_MARK);
    send_word(OP_BYTE, 8'hAA);
    send_word(OP_BYTE, 8'h55);
    send_word(OP_UNUSED, 8'h5A);
    send_word(OP_ERROR, 8'h00);
    send_word(OP_ERROR, 8'h3C);
    send_word(OP_BYTE, 8'hC3);
    send_word(OP_ERROR, 8'h00);
  endtask

  task automatic test_block_extremes;
    // block 0 sent again in full: model byte rewritten, checksum wraps
    send_block(SEND_GOOD, FILL_ONES, 1'b0);
  endtask

  task automatic test_backpressure;
    wait_drained();
    long_hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_word(OP_BYTE, 8'($urandom));
    wait_drained();
    send_word(OP_ERROR, 8'($urandom));
  endtask

  task automatic test_random_blocks;
    int    start;
    int    pick;
    fill_e fill;
    start = word_count;
    while (word_count - start < 800) begin
      pick = $urandom_range(0, 99);
      fill = FILL_RANDOM;
      if ($urandom_range(0, 7) == 0) fill = ($urandom_range(0, 1) == 1) ? FILL_ZERO : FILL_ONES;
      if (pick < 40) send_block(SEND_GOOD, fill, 1'($urandom_range(0, 1)));
      else if (pick < 55) send_block(SEND_BAD_SUM, fill, 1'($urandom_range(0, 1)));
      else if (pick < 70) send_block(SEND_ERR_SUM, fill, 1'($urandom_range(0, 1)));
      else send_block(SEND_ERR_DATA, fill, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  task automatic test_cancel;
    idle_on = 1'b0;
    for (int i = 0; i < 60; i++) send_word(OP_BYTE, 8'($urandom));
    send_word(OP_CANCEL, 8'($urandom));
    send_word(OP_BYTE, 8'h20);
    send_word(OP_ERROR, 8'h00);
    send_word(OP_CANCEL, 8'hFF);
    send_word(OP_UNUSED, 8'h11);
    send_word(OP_BYTE, 8'hDA);
  endtask

  initial begin
    rx_pos = '0;
    rx_sum = '0;
    rx_chk_hi = '0;
    rx_blk = 0;
    rx_none_yet = 1'b1;
    rx_model = 1'b0;
    rx_phase = PH_RECEIVING;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_BYTE;
    in_if.rx_byte <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_link_events();
    test_block_extremes();
    test_backpressure();
    test_random_blocks();
    test_cancel();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
